### design/tecc_pkg.sv
// Shared types, constants and codes for the bridge-connected components block.
package tecc_pkg;

  // Graph capacity and field widths.
  localparam int VTX_W    = 10;
  localparam int VTX_N    = 1024;
  localparam int EDGE_W   = 12;
  localparam int EDGE_N   = 4096;
  localparam int HALF_W   = 13;
  localparam int PTR_W    = 14;
  localparam int EPLUS_W  = 13;
  localparam int ECNT_W   = 13;
  localparam int TIME_W   = 11;
  localparam int NV_W     = 11;

  // Register index decoded from the configuration address.
  localparam logic REG_NUM_VERTICES = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_UNBUILT = 2'd3
  } status_e_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [VTX_W-1:0] node_a;
    logic [VTX_W-1:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       same_component;
  } out_item_t;

  // One search frame: vertex, parent edge + 1, cursor (half-edge + 1), low link, entry time.
  typedef struct packed {
    logic [VTX_W-1:0]   vertex;
    logic [EPLUS_W-1:0] pe;
    logic [PTR_W-1:0]   cursor;
    logic [TIME_W-1:0]  low;
    logic [TIME_W-1:0]  ent;
  } frame_t;

  typedef enum logic [4:0] {
    S_CLRH, S_IDLE, S_DISP, S_ADD_WA, S_ADD_RB, S_ADD_WB, S_Q_RB, S_Q_FIN,
    S_B_CLR, S_B_ROOT, S_B_RCHK, S_B_ENT0, S_B_ENT1, S_B_STEP, S_B_EDGE,
    S_B_UCHK, S_B_POP, S_B_LRD, S_B_LWR, S_OUT
  } state_e_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_head_step;
    logic clr_ent_step;
    logic clr_reset;
    logic latch_in;
    logic add_rd_a;
    logic add_wr_a;
    logic add_rd_b;
    logic add_wr_b;
    logic res_add_err;
    logic q_rd_a;
    logic q_rd_b;
    logic q_fin;
    logic res_ok;
    logic b_init;
    logic b_done;
    logic root_rd;
    logic root_next;
    logic ent_rd_head;
    logic ent_wr;
    logic step_rd;
    logic edge_eval;
    logic u_eval;
    logic pop_rd;
    logic pop_eval;
    logic lbl_start;
    logic lbl_all_sel;
    logic lbl_rd;
    logic lbl_wr;
    logic out_load;
  } tecc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_e_t op;
    logic      add_err;
    logic      clr_last;
    logic      root_done;
    logic      root_seen;
    logic      has_cursor;
    logic      fr_empty;
    logic      skip;
    logic      u_new;
    logic      bridge;
    logic      stk_empty;
    logic      lbl_stop;
    logic      lbl_all;
    logic      out_free;
  } tecc_sts_t;

endpackage

### design/tecc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tecc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/tecc_ctrl.sv
// Controller state machine sequencing edge loads, queries and the bridge search.
module tecc_ctrl import tecc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tecc_sts_t sts,
  output tecc_cmd_t cmd
);

  state_e_t state_r;
  state_e_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLRH;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLRH:   if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        case (sts.op)
          OP_ADD:   state_nxt = sts.add_err ? S_OUT : S_ADD_WA;
          OP_BUILD: state_nxt = S_B_CLR;
          OP_QUERY: state_nxt = S_Q_RB;
          default:  state_nxt = S_OUT;
        endcase
      end
      S_ADD_WA: state_nxt = S_ADD_RB;
      S_ADD_RB: state_nxt = S_ADD_WB;
      S_ADD_WB: state_nxt = S_OUT;
      S_Q_RB:   state_nxt = S_Q_FIN;
      S_Q_FIN:  state_nxt = S_OUT;
      S_B_CLR:  if (sts.clr_last) state_nxt = S_B_ROOT;
      S_B_ROOT: state_nxt = sts.root_done ? S_OUT : S_B_RCHK;
      S_B_RCHK: state_nxt = sts.root_seen ? S_B_ROOT : S_B_ENT0;
      S_B_ENT0: state_nxt = S_B_ENT1;
      S_B_ENT1: state_nxt = S_B_STEP;
      S_B_STEP: begin
        if (sts.has_cursor) begin
          state_nxt = S_B_EDGE;
        end else if (sts.fr_empty) begin
          state_nxt = S_B_LRD;
        end else begin
          state_nxt = S_B_POP;
        end
      end
      S_B_EDGE: state_nxt = sts.skip ? S_B_STEP : S_B_UCHK;
      S_B_UCHK: state_nxt = sts.u_new ? S_B_ENT0 : S_B_STEP;
      S_B_POP:  state_nxt = sts.bridge ? S_B_LRD : S_B_STEP;
      S_B_LRD: begin
        if (sts.stk_empty) begin
          state_nxt = sts.lbl_all ? S_B_ROOT : S_B_STEP;
        end else begin
          state_nxt = S_B_LWR;
        end
      end
      S_B_LWR:  state_nxt = sts.lbl_stop ? S_B_STEP : S_B_LRD;
      S_OUT:    if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    case (state_r)
      S_CLRH:   cmd.clr_head_step = 1'b1;
      S_IDLE:   cmd.latch_in = in_valid;
      S_DISP: begin
        case (sts.op)
          OP_ADD: begin
            if (sts.add_err) begin
              cmd.res_add_err = 1'b1;
            end else begin
              cmd.add_rd_a = 1'b1;
            end
          end
          OP_BUILD: cmd.clr_reset = 1'b1;
          OP_QUERY: cmd.q_rd_a = 1'b1;
          default:  cmd.res_ok = 1'b1;
        endcase
      end
      S_ADD_WA: cmd.add_wr_a = 1'b1;
      S_ADD_RB: cmd.add_rd_b = 1'b1;
      S_ADD_WB: cmd.add_wr_b = 1'b1;
      S_Q_RB:   cmd.q_rd_b = 1'b1;
      S_Q_FIN:  cmd.q_fin = 1'b1;
      S_B_CLR: begin
        cmd.clr_ent_step = 1'b1;
        cmd.b_init       = sts.clr_last;
      end
      S_B_ROOT: begin
        cmd.b_done  = sts.root_done;
        cmd.root_rd = !sts.root_done;
      end
      S_B_RCHK: cmd.root_next = sts.root_seen;
      S_B_ENT0: cmd.ent_rd_head = 1'b1;
      S_B_ENT1: cmd.ent_wr = 1'b1;
      S_B_STEP: begin
        if (sts.has_cursor) begin
          cmd.step_rd = 1'b1;
        end else if (sts.fr_empty) begin
          cmd.lbl_start   = 1'b1;
          cmd.lbl_all_sel = 1'b1;
        end else begin
          cmd.pop_rd = 1'b1;
        end
      end
      S_B_EDGE: cmd.edge_eval = 1'b1;
      S_B_UCHK: cmd.u_eval = 1'b1;
      S_B_POP: begin
        cmd.pop_eval  = 1'b1;
        cmd.lbl_start = sts.bridge;
      end
      S_B_LRD: begin
        cmd.lbl_rd    = !sts.stk_empty;
        cmd.root_next = sts.stk_empty && sts.lbl_all;
      end
      S_B_LWR:  cmd.lbl_wr = 1'b1;
      S_OUT:    cmd.out_load = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

### design/tecc_dp.sv
// Datapath: graph memories, search registers, configuration and result registers.
module tecc_dp import tecc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tecc_cmd_t   cmd,
  output tecc_sts_t   sts,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        out_stall,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Control registers.
  logic [NV_W-1:0]   nv_r;
  logic              built_r;
  logic [ECNT_W-1:0] etot_r;
  logic [VTX_W-1:0]  clr_r;
  logic [NV_W-1:0]   st_top_r;
  logic [NV_W-1:0]   fr_top_r;
  logic              cur_valid_r;
  logic              out_valid_r;

  // Payload registers.
  opcode_e_t          op_r;
  logic [VTX_W-1:0]   a_r;
  logic [VTX_W-1:0]   b_r;
  out_item_t          res_r;
  out_item_t          out_data_r;
  logic [NV_W-1:0]    root_r;
  logic [TIME_W-1:0]  clk_cnt_r;
  logic [TIME_W-1:0]  lbl_cnt_r;
  frame_t             cur_r;
  logic [VTX_W-1:0]   x_r;
  logic [EPLUS_W-1:0] pe_new_r;
  logic [HALF_W-1:0]  h_r;
  logic [VTX_W-1:0]   child_r;
  logic               lbl_all_r;
  logic [TIME_W-1:0]  la_r;

  // Memory ports.
  logic               head_we, head_re;
  logic [VTX_W-1:0]   head_waddr, head_raddr;
  logic [PTR_W-1:0]   head_wdata, head_rdata;
  logic               adjn_we, adjn_re;
  logic [HALF_W-1:0]  adjn_waddr, adjn_raddr;
  logic [PTR_W-1:0]   adjn_rdata;
  logic               edge_we, edge_re;
  logic [EDGE_W-1:0]  edge_waddr, edge_raddr;
  logic [2*VTX_W-1:0] edge_wdata, edge_rdata;
  logic               ent_we, ent_re;
  logic [VTX_W-1:0]   ent_waddr, ent_raddr;
  logic [TIME_W-1:0]  ent_wdata, ent_rdata;
  logic               lbl_we, lbl_re;
  logic [VTX_W-1:0]   lbl_raddr;
  logic [TIME_W-1:0]  lbl_rdata;
  logic               stk_we, stk_re;
  logic [VTX_W-1:0]   stk_rdata;
  logic               frm_we, frm_re;
  frame_t             frm_rdata;

  // Derived values.
  logic [PTR_W-1:0]   half_a;
  logic [PTR_W-1:0]   h_step;
  logic [NV_W-1:0]    st_dec, fr_dec;
  logic [VTX_W-1:0]   u_sel;
  logic [EPLUS_W-1:0] e_plus;
  logic [TIME_W-1:0]  clk_inc;
  logic               a_oor, b_oor;
  logic               cfg_wr;
  logic [NV_W-1:0]    nv_nxt;

  assign half_a  = {1'b0, etot_r[EDGE_W-1:0], 1'b1};
  assign h_step  = cur_r.cursor - PTR_W'(1);
  assign st_dec  = st_top_r - NV_W'(1);
  assign fr_dec  = fr_top_r - NV_W'(1);
  assign u_sel   = h_r[0] ? edge_rdata[2*VTX_W-1:VTX_W] : edge_rdata[VTX_W-1:0];
  assign e_plus  = {1'b0, h_r[HALF_W-1:1]} + EPLUS_W'(1);
  assign clk_inc = clk_cnt_r + TIME_W'(1);
  assign a_oor   = {1'b0, a_r} >= nv_r;
  assign b_oor   = {1'b0, b_r} >= nv_r;

  // Port muxing for the memories.
  assign head_we    = cmd.clr_head_step | cmd.add_wr_a | cmd.add_wr_b;
  assign head_waddr = cmd.clr_head_step ? clr_r : (cmd.add_wr_a ? a_r : b_r);
  assign head_wdata = cmd.clr_head_step ? '0 :
                      (cmd.add_wr_a ? half_a : half_a + PTR_W'(1));
  assign head_re    = cmd.add_rd_a | cmd.add_rd_b | cmd.ent_rd_head;
  assign head_raddr = cmd.add_rd_a ? a_r : (cmd.add_rd_b ? b_r : x_r);

  assign adjn_we    = cmd.add_wr_a | cmd.add_wr_b;
  assign adjn_waddr = {etot_r[EDGE_W-1:0], cmd.add_wr_b};
  assign adjn_re    = cmd.step_rd;
  assign adjn_raddr = h_step[HALF_W-1:0];

  assign edge_we    = cmd.add_wr_b;
  assign edge_waddr = etot_r[EDGE_W-1:0];
  assign edge_wdata = {a_r, b_r};
  assign edge_re    = cmd.step_rd;
  assign edge_raddr = h_step[HALF_W-1:1];

  assign ent_we     = cmd.clr_ent_step | cmd.ent_wr;
  assign ent_waddr  = cmd.clr_ent_step ? clr_r : x_r;
  assign ent_wdata  = cmd.clr_ent_step ? '0 : clk_inc;
  assign ent_re     = cmd.root_rd | cmd.edge_eval;
  assign ent_raddr  = cmd.root_rd ? root_r[VTX_W-1:0] : u_sel;

  assign lbl_we     = cmd.lbl_wr;
  assign lbl_re     = cmd.q_rd_a | cmd.q_rd_b;
  assign lbl_raddr  = cmd.q_rd_a ? a_r : b_r;

  assign stk_we     = cmd.ent_wr;
  assign stk_re     = cmd.lbl_rd;
  assign frm_we     = cmd.ent_wr & cur_valid_r;
  assign frm_re     = cmd.pop_rd;

  tecc_ram #(.WIDTH(PTR_W), .DEPTH(VTX_N)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
  );

  tecc_ram #(.WIDTH(PTR_W), .DEPTH(2*EDGE_N)) u_adjn (
    .clk(clk), .we(adjn_we), .waddr(adjn_waddr), .wdata(head_rdata),
    .re(adjn_re), .raddr(adjn_raddr), .rdata(adjn_rdata)
  );

  tecc_ram #(.WIDTH(2*VTX_W), .DEPTH(EDGE_N)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
  );

  tecc_ram #(.WIDTH(TIME_W), .DEPTH(VTX_N)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
  );

  tecc_ram #(.WIDTH(TIME_W), .DEPTH(VTX_N)) u_lbl (
    .clk(clk), .we(lbl_we), .waddr(stk_rdata), .wdata(lbl_cnt_r),
    .re(lbl_re), .raddr(lbl_raddr), .rdata(lbl_rdata)
  );

  tecc_ram #(.WIDTH(VTX_W), .DEPTH(VTX_N)) u_stk (
    .clk(clk), .we(stk_we), .waddr(st_top_r[VTX_W-1:0]), .wdata(x_r),
    .re(stk_re), .raddr(st_dec[VTX_W-1:0]), .rdata(stk_rdata)
  );

  tecc_ram #(.WIDTH($bits(frame_t)), .DEPTH(VTX_N)) u_frm (
    .clk(clk), .we(frm_we), .waddr(fr_top_r[VTX_W-1:0]), .wdata(cur_r),
    .re(frm_re), .raddr(fr_dec[VTX_W-1:0]), .rdata(frm_rdata)
  );

  // Configuration write decode and saturation of the vertex count.
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                  (cfg_paddr[2] == REG_NUM_VERTICES);

  always_comb begin
    nv_nxt = cfg_pwdata[NV_W-1:0];
    if (nv_nxt == '0) begin
      nv_nxt = NV_W'(1);
    end else if (nv_nxt > NV_W'(VTX_N)) begin
      nv_nxt = NV_W'(VTX_N);
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_NUM_VERTICES) ? {{(32-NV_W){1'b0}}, nv_r} : '0;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r        <= NV_W'(VTX_N);
      built_r     <= 1'b0;
      etot_r      <= '0;
      clr_r       <= '0;
      st_top_r    <= '0;
      fr_top_r    <= '0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        nv_r    <= nv_nxt;
        built_r <= 1'b0;
      end
      if (cmd.add_wr_b) begin
        etot_r  <= etot_r + ECNT_W'(1);
        built_r <= 1'b0;
      end
      if (cmd.b_done) begin
        built_r <= 1'b1;
      end
      if (cmd.clr_reset) begin
        clr_r <= '0;
      end else if (cmd.clr_head_step || cmd.clr_ent_step) begin
        clr_r <= clr_r + VTX_W'(1);
      end
      if (cmd.b_init) begin
        st_top_r    <= '0;
        fr_top_r    <= '0;
        cur_valid_r <= 1'b0;
      end
      if (cmd.ent_wr) begin
        st_top_r    <= st_top_r + NV_W'(1);
        cur_valid_r <= 1'b1;
        if (cur_valid_r) begin
          fr_top_r <= fr_top_r + NV_W'(1);
        end
      end
      if (cmd.pop_eval) begin
        fr_top_r <= fr_dec;
      end
      if (cmd.lbl_start && cmd.lbl_all_sel) begin
        cur_valid_r <= 1'b0;
      end
      if (cmd.lbl_rd) begin
        st_top_r <= st_dec;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and search registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r <= opcode_e_t'(in_data.opcode);
      a_r  <= in_data.node_a;
      b_r  <= in_data.node_b;
    end
    if (cmd.b_init) begin
      clk_cnt_r <= '0;
      lbl_cnt_r <= '0;
      root_r    <= '0;
    end
    if (cmd.root_next) begin
      root_r <= root_r + NV_W'(1);
    end
    if (cmd.root_rd) begin
      x_r      <= root_r[VTX_W-1:0];
      pe_new_r <= '0;
    end
    if (cmd.ent_wr) begin
      cur_r     <= '{vertex: x_r, pe: pe_new_r, cursor: head_rdata,
                     low: clk_inc, ent: clk_inc};
      clk_cnt_r <= clk_inc;
    end
    if (cmd.step_rd) begin
      h_r <= h_step[HALF_W-1:0];
    end
    if (cmd.edge_eval) begin
      cur_r.cursor <= adjn_rdata;
      x_r          <= u_sel;
      pe_new_r     <= e_plus;
    end
    if (cmd.u_eval && ent_rdata != '0 && ent_rdata < cur_r.low) begin
      cur_r.low <= ent_rdata;
    end
    if (cmd.pop_rd) begin
      child_r <= cur_r.vertex;
    end
    // The parent frame comes back with the child's low link folded in.
    if (cmd.pop_eval) begin
      cur_r <= '{vertex: frm_rdata.vertex, pe: frm_rdata.pe, cursor: frm_rdata.cursor,
                 low: (cur_r.low < frm_rdata.low) ? cur_r.low : frm_rdata.low,
                 ent: frm_rdata.ent};
    end
    if (cmd.lbl_start) begin
      lbl_cnt_r <= lbl_cnt_r + TIME_W'(1);
      lbl_all_r <= cmd.lbl_all_sel;
    end
    if (cmd.q_rd_b) begin
      la_r <= lbl_rdata;
    end
    // Result of the item in hand.
    if (cmd.res_add_err) begin
      res_r <= '{status: (a_oor || b_oor) ? ST_RANGE : ST_FULL, same_component: 1'b0};
    end
    if (cmd.add_wr_b || cmd.res_ok || cmd.b_done) begin
      res_r <= '{status: ST_OK, same_component: 1'b0};
    end
    if (cmd.q_fin) begin
      if (a_oor || b_oor) begin
        res_r <= '{status: ST_RANGE, same_component: 1'b0};
      end else if (!built_r) begin
        res_r <= '{status: ST_UNBUILT, same_component: 1'b0};
      end else begin
        res_r <= '{status: ST_OK, same_component: (la_r == lbl_rdata)};
      end
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.add_err    = a_oor || b_oor || (etot_r >= ECNT_W'(EDGE_N));
    sts.clr_last   = &clr_r;
    sts.root_done  = root_r >= nv_r;
    sts.root_seen  = ent_rdata != '0;
    sts.has_cursor = cur_r.cursor != '0;
    sts.fr_empty   = fr_top_r == '0;
    sts.skip       = (e_plus == cur_r.pe) || ({1'b0, u_sel} >= nv_r);
    sts.u_new      = ent_rdata == '0;
    sts.bridge     = cur_r.low > frm_rdata.ent;
    sts.stk_empty  = st_top_r == '0;
    sts.lbl_stop   = !lbl_all_r && (stk_rdata == child_r);
    sts.lbl_all    = lbl_all_r;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Stored frames are ancestors of the current vertex, all still on the vertex stack.
  a_frames_on_stack: assert property (@(posedge clk) disable iff (!rst_n)
    fr_top_r <= st_top_r)
    else $error("frame count exceeds vertex stack depth");

  // The edge count never passes the store size.
  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    etot_r <= ECNT_W'(EDGE_N))
    else $error("edge count beyond store size");

  // The vertex count stays within its saturated range.
  a_nv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nv_r != '0) && (nv_r <= NV_W'(VTX_N)))
    else $error("vertex count out of range");

  // A stored edge invalidates any earlier build.
  a_add_clears_built: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_wr_b |=> !built_r)
    else $error("built flag survived an edge load");
`endif

endmodule

### design/two_edge_connected_components_top.sv
// Top level of the bridge-connected components block.
//
// Input beats carry an opcode and two vertices: add an undirected edge, build the
// components, or query whether two vertices share a component. Every input beat
// gives exactly one result beat with a status and, for queries, the answer.
// The input channel takes one beat at a time; in_stall stays high from acceptance
// until the result has moved into the output register, so a finished result may
// wait there for the receiver while the next beat is already accepted.
// Edge loads and queries are sequenced by the single-port reads of the head list
// and label memories. A rejected edge or an unused opcode goes from dispatch
// straight to the output state.
// A build runs the entry time clearing sweep and then the search over the
// vertices and stored half-edges, labelling each component as its bridge is
// found or its search tree is finished. While out_stall is high a valid result
// beat holds and no result replaces it. After reset a clearing pass empties
// every adjacency head entry; no input beat is accepted meanwhile, configuration
// writes are taken as ever. The user writes num_vertices over the configuration
// port while the block is idle; the block does not enforce it.
module two_edge_connected_components_top import tecc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tecc_cmd_t cmd;
  tecc_sts_t sts;

  // Sequencer.
  tecc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memories, search registers and port registers.
  tecc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

endmodule
